// ===== sv/imuoc_pkg.sv =====
// ----------------------------------------------------------------------------
// imuoc_pkg
// Shared types and constants of the IMU offset calibrator: payload structs,
// configuration struct, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package imuoc_pkg;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] accel_x_offset;
    logic signed [15:0] accel_y_offset;
    logic signed [15:0] accel_z_offset;
    logic signed [15:0] gyro_x_offset;
    logic signed [15:0] gyro_y_offset;
    logic signed [15:0] gyro_z_offset;
    logic              converged;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  warmup_discard;
    logic [7:0]  accel_deadzone;
    logic [7:0]  gyro_deadzone;
    logic [14:0] accel_one_g;
  } cfg_t;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [2:0] REG_WARMUP_DISCARD = 3'd1;
  localparam logic [2:0] REG_ACCEL_DEADZONE = 3'd2;
  localparam logic [2:0] REG_GYRO_DEADZONE  = 3'd3;
  localparam logic [2:0] REG_ACCEL_ONE_G    = 3'd4;

  localparam int unsigned RST_SAMPLE_COUNT   = 1000;
  localparam logic [7:0]  RST_WARMUP_DISCARD = 8'd101;
  localparam logic [7:0]  RST_ACCEL_DEADZONE = 8'd8;
  localparam logic [7:0]  RST_GYRO_DEADZONE  = 8'd1;
  localparam logic [14:0] RST_ACCEL_ONE_G    = 15'd16384;

  localparam int unsigned NUM_AXES    = 6;
  localparam int unsigned ACCEL_AXES  = 3;
  localparam logic [2:0]  AXIS_FIRST  = 3'd0;
  localparam logic [2:0]  AXIS_ACC_Z  = 3'd2;
  localparam logic [2:0]  AXIS_LAST   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_FIRST,
    ST_CHECK,
    ST_CORR_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       start_cal;
    logic       sample;
    logic       div_start;
    logic       div_corr;
    logic       store_mean;
    logic       first_update;
    logic       corr_update;
    logic       emit;
    logic       converged;
    logic [2:0] axis;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic settled;
    logic div_done;
    logic out_room;
  } sts_t;

endpackage

// ===== sv/imu_offset_calibrator.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibrator
// Six-axis IMU offset calibration with separate accelerometer and gyroscope deadzones.
// ----------------------------------------------------------------------------
// A start transfer clears the offsets and returns them as zero at once. Sensor
// samples then accumulate; the first warmup_discard samples of a
// round are dropped and the next sample_count are summed. The sample that
// closes a round starts the round-end sequence, during which input stalls:
// six mean divisions on the single shared restoring divider, then in the
// first round a direct offset update, in later rounds a deadzone check per
// axis and a correction division for each axis outside its deadzone, then
// the load of the result register, which waits for room. A result waiting in
// the output register does not block samples; only a start transfer and the
// next result load wait for it. Calibration stops when a round reports all six
// axes converged.
// ----------------------------------------------------------------------------
module imu_offset_calibrator #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  imuoc_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output imuoc_pkg::out_item_t             out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [imuoc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [imuoc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [imuoc_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  logic [COUNT_BITS-1:0] sample_count;
  imuoc_pkg::cfg_t       cfg;
  imuoc_pkg::cmd_t       cmd;
  imuoc_pkg::sts_t       sts;

  imuoc_regs #(
    .COUNT_BITS (COUNT_BITS)
  ) u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_count_o (sample_count),
    .cfg_o          (cfg)
  );

  imuoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_data_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  imuoc_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_data_i      (in_data_i),
    .sample_count_i (sample_count),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

// ===== sv/imuoc_div.sv =====
// ----------------------------------------------------------------------------
// imuoc_div
// Restoring divider, one quotient bit per cycle. Signed dividend, unsigned
// non-zero divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module imuoc_div #(
  parameter int unsigned NW  = 29,
  parameter int unsigned DVW = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] dividend_i,
  input  logic [DVW-1:0]       divisor_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q, raw, mag;
  logic [DVW-1:0] rem_q, dvs_q, rem_d;
  logic [DVW:0]  trial, diff;
  logic          ge;

  assign raw   = dividend_i;
  assign mag   = raw[NW-1] ? -raw : raw;
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[DVW-1:0] : trial[DVW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= divisor_i;
      neg_q <= raw[NW-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

// ===== sv/imuoc_regs.sv =====
// ----------------------------------------------------------------------------
// imuoc_regs
// APB configuration registers of the calibrator.
// ----------------------------------------------------------------------------
module imuoc_regs #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [imuoc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [imuoc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [imuoc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  output logic [COUNT_BITS-1:0]              sample_count_o,
  output imuoc_pkg::cfg_t                    cfg_o
);

  logic [COUNT_BITS-1:0] sample_count_q;
  imuoc_pkg::cfg_t       cfg_q;
  logic [2:0]            reg_idx;
  logic                  wr_en;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q       <= COUNT_BITS'(imuoc_pkg::RST_SAMPLE_COUNT);
      cfg_q.warmup_discard <= imuoc_pkg::RST_WARMUP_DISCARD;
      cfg_q.accel_deadzone <= imuoc_pkg::RST_ACCEL_DEADZONE;
      cfg_q.gyro_deadzone  <= imuoc_pkg::RST_GYRO_DEADZONE;
      cfg_q.accel_one_g    <= imuoc_pkg::RST_ACCEL_ONE_G;
    end else if (wr_en) begin
      case (reg_idx)
        imuoc_pkg::REG_SAMPLE_COUNT:   sample_count_q       <= pwdata[COUNT_BITS-1:0];
        imuoc_pkg::REG_WARMUP_DISCARD: cfg_q.warmup_discard <= pwdata[7:0];
        imuoc_pkg::REG_ACCEL_DEADZONE: cfg_q.accel_deadzone <= pwdata[7:0];
        imuoc_pkg::REG_GYRO_DEADZONE:  cfg_q.gyro_deadzone  <= pwdata[7:0];
        imuoc_pkg::REG_ACCEL_ONE_G:    cfg_q.accel_one_g    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      imuoc_pkg::REG_SAMPLE_COUNT:   prdata = imuoc_pkg::APB_DATA_W'(sample_count_q);
      imuoc_pkg::REG_WARMUP_DISCARD: prdata = imuoc_pkg::APB_DATA_W'(cfg_q.warmup_discard);
      imuoc_pkg::REG_ACCEL_DEADZONE: prdata = imuoc_pkg::APB_DATA_W'(cfg_q.accel_deadzone);
      imuoc_pkg::REG_GYRO_DEADZONE:  prdata = imuoc_pkg::APB_DATA_W'(cfg_q.gyro_deadzone);
      imuoc_pkg::REG_ACCEL_ONE_G:    prdata = imuoc_pkg::APB_DATA_W'(cfg_q.accel_one_g);
      default:                       prdata = '0;
    endcase
  end

  assign sample_count_o = sample_count_q;
  assign cfg_o          = cfg_q;

endmodule

// ===== sv/imuoc_dpath.sv =====
// ----------------------------------------------------------------------------
// imuoc_dpath
// Datapath: sample counter, six axis sums, six offsets, the shared divider
// and the result register.
// ----------------------------------------------------------------------------
module imuoc_dpath #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imuoc_pkg::cmd_t       cmd_i,
  output imuoc_pkg::sts_t       sts_o,
  input  imuoc_pkg::in_item_t   in_data_i,
  input  logic [COUNT_BITS-1:0] sample_count_i,
  input  imuoc_pkg::cfg_t       cfg_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output imuoc_pkg::out_item_t  out_data_o
);

  localparam int unsigned SW    = COUNT_BITS + 16;
  localparam int unsigned EW    = SW + 1;
  localparam int unsigned IDX_W = ((COUNT_BITS > 8) ? COUNT_BITS : 8) + 1;
  localparam int unsigned DVW   = (COUNT_BITS > 9) ? COUNT_BITS : 9;
  localparam logic signed [EW:0] SAT_MAX = (EW+1)'(32767);
  localparam logic signed [EW:0] SAT_MIN = (EW+1)'(-32768);

  function automatic logic signed [15:0] sat16(input logic signed [EW:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) r = 16'sh7fff;
    else if (v < SAT_MIN) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  logic signed [SW-1:0] sums_q [imuoc_pkg::NUM_AXES];
  logic signed [15:0]   offs_q [imuoc_pkg::NUM_AXES];
  logic [IDX_W-1:0]     idx_q;
  logic                 out_valid_q;
  imuoc_pkg::out_item_t out_data_q;

  logic signed [15:0]   smp [imuoc_pkg::NUM_AXES];
  logic signed [EW-1:0] err_all [imuoc_pkg::NUM_AXES];
  logic signed [15:0]   first_off [imuoc_pkg::NUM_AXES];
  logic signed [EW-1:0] one_g, err_sel, bias, shifted, div_a, quot;
  logic [EW-1:0]        err_u, err_abs;
  logic [COUNT_BITS-1:0] n_eff;
  logic [7:0]           adiv, dz;
  logic [8:0]           gdiv;
  logic [DVW-1:0]       div_d;
  logic                 last, acc_en, div_done;
  logic signed [15:0]   corr_off;

  assign smp[0] = in_data_i.accel_x;
  assign smp[1] = in_data_i.accel_y;
  assign smp[2] = in_data_i.accel_z;
  assign smp[3] = in_data_i.gyro_x;
  assign smp[4] = in_data_i.gyro_y;
  assign smp[5] = in_data_i.gyro_z;

  assign n_eff  = (sample_count_i == '0) ? COUNT_BITS'(1) : sample_count_i;
  assign last   = ({1'b0, idx_q} + (IDX_W+1)'(1)) >=
                  ((IDX_W+1)'(cfg_i.warmup_discard) + (IDX_W+1)'(n_eff));
  assign acc_en = idx_q >= IDX_W'(cfg_i.warmup_discard);
  assign one_g  = EW'($signed({1'b0, cfg_i.accel_one_g}));

  always_comb begin
    for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
      if (k == int'(imuoc_pkg::AXIS_ACC_Z)) err_all[k] = one_g - EW'(sums_q[k]);
      else err_all[k] = -EW'(sums_q[k]);
      bias = '0;
      if (err_all[k][EW-1]) bias = (k < imuoc_pkg::ACCEL_AXES) ? EW'(7) : EW'(3);
      shifted = (err_all[k] + bias) >>> ((k < imuoc_pkg::ACCEL_AXES) ? 3 : 2);
      first_off[k] = sat16((EW+1)'(shifted));
    end
  end

  assign err_sel = err_all[cmd_i.axis];
  assign err_u   = err_sel;
  assign err_abs = err_u[EW-1] ? -err_u : err_u;
  assign adiv    = (cfg_i.accel_deadzone == 8'd0) ? 8'd1 : cfg_i.accel_deadzone;
  assign gdiv    = {1'b0, cfg_i.gyro_deadzone} + 9'd1;
  assign dz      = (cmd_i.axis < imuoc_pkg::AXIS_LAST - 3'd2) ? cfg_i.accel_deadzone
                                                             : cfg_i.gyro_deadzone;

  always_comb begin
    if (cmd_i.div_corr) begin
      div_a = err_sel;
      if (cmd_i.axis < imuoc_pkg::AXIS_LAST - 3'd2) div_d = DVW'(adiv);
      else div_d = DVW'(gdiv);
    end else begin
      div_a = EW'(sums_q[cmd_i.axis]);
      div_d = DVW'(n_eff);
    end
  end

  imuoc_div #(
    .NW  (EW),
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign corr_off = sat16((EW+1)'(offs_q[cmd_i.axis]) + (EW+1)'(quot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
        sums_q[k] <= '0;
        offs_q[k] <= '0;
      end
      idx_q <= '0;
    end else begin
      if (cmd_i.start_cal) begin
        for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
          sums_q[k] <= '0;
          offs_q[k] <= '0;
        end
        idx_q <= '0;
      end
      if (cmd_i.sample) begin
        idx_q <= last ? '0 : idx_q + IDX_W'(1);
        if (acc_en) begin
          for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
            sums_q[k] <= sums_q[k] + SW'(smp[k]);
          end
        end
      end
      if (cmd_i.store_mean) sums_q[cmd_i.axis] <= SW'(quot);
      if (cmd_i.first_update) begin
        for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) offs_q[k] <= first_off[k];
      end
      if (cmd_i.corr_update) offs_q[cmd_i.axis] <= corr_off;
      if (cmd_i.emit) begin
        for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) sums_q[k] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.start_cal || cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_cal) begin
      out_data_q <= '0;
    end else if (cmd_i.emit) begin
      out_data_q.accel_x_offset <= offs_q[0];
      out_data_q.accel_y_offset <= offs_q[1];
      out_data_q.accel_z_offset <= offs_q[2];
      out_data_q.gyro_x_offset  <= offs_q[3];
      out_data_q.gyro_y_offset  <= offs_q[4];
      out_data_q.gyro_z_offset  <= offs_q[5];
      out_data_q.converged      <= cmd_i.converged;
    end
  end

  assign sts_o.last     = last;
  assign sts_o.settled  = err_abs <= EW'(dz);
  assign sts_o.div_done = div_done;
  assign sts_o.out_room = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/imuoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// imuoc_ctrl
// Controller: sequences sample intake, the mean and correction divisions
// over the six axes, and the result transfer.
// ----------------------------------------------------------------------------
module imuoc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_kind_i,
  output logic            in_stall_o,
  input  imuoc_pkg::sts_t sts_i,
  output imuoc_pkg::cmd_t cmd_o
);

  imuoc_pkg::state_e state_q, state_d;
  logic [2:0]        axis_q, axis_d;
  logic              first_q, first_d;
  logic              all_q, all_d;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imuoc_pkg::ST_IDLE;
      axis_q  <= imuoc_pkg::AXIS_FIRST;
      first_q <= 1'b0;
      all_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      first_q <= first_d;
      all_q   <= all_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    first_d = first_q;
    all_d   = all_q;
    cmd_o   = '0;
    cmd_o.axis = axis_q;

    in_stall_o = !(state_q == imuoc_pkg::ST_IDLE || state_q == imuoc_pkg::ST_ACCUM) ||
                 (in_kind_i && !sts_i.out_room);
    accept = in_valid_i && !in_stall_o;

    case (state_q)
      imuoc_pkg::ST_IDLE: begin
        if (accept && in_kind_i) begin
          cmd_o.start_cal = 1'b1;
          first_d = 1'b1;
          state_d = imuoc_pkg::ST_ACCUM;
        end
      end
      imuoc_pkg::ST_ACCUM: begin
        if (accept) begin
          if (in_kind_i) begin
            cmd_o.start_cal = 1'b1;
            first_d = 1'b1;
          end else begin
            cmd_o.sample = 1'b1;
            if (sts_i.last) begin
              axis_d  = imuoc_pkg::AXIS_FIRST;
              state_d = imuoc_pkg::ST_MEAN_GO;
            end
          end
        end
      end
      imuoc_pkg::ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = imuoc_pkg::ST_MEAN_WAIT;
      end
      imuoc_pkg::ST_MEAN_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.store_mean = 1'b1;
          if (axis_q == imuoc_pkg::AXIS_LAST) begin
            axis_d  = imuoc_pkg::AXIS_FIRST;
            all_d   = 1'b1;
            state_d = first_q ? imuoc_pkg::ST_FIRST : imuoc_pkg::ST_CHECK;
          end else begin
            axis_d  = axis_q + 3'd1;
            state_d = imuoc_pkg::ST_MEAN_GO;
          end
        end
      end
      imuoc_pkg::ST_FIRST: begin
        cmd_o.first_update = 1'b1;
        state_d = imuoc_pkg::ST_EMIT;
      end
      imuoc_pkg::ST_CHECK: begin
        cmd_o.div_corr = 1'b1;
        if (sts_i.settled) begin
          if (axis_q == imuoc_pkg::AXIS_LAST) state_d = imuoc_pkg::ST_EMIT;
          else axis_d = axis_q + 3'd1;
        end else begin
          cmd_o.div_start = 1'b1;
          all_d   = 1'b0;
          state_d = imuoc_pkg::ST_CORR_WAIT;
        end
      end
      imuoc_pkg::ST_CORR_WAIT: begin
        cmd_o.div_corr = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.corr_update = 1'b1;
          if (axis_q == imuoc_pkg::AXIS_LAST) begin
            state_d = imuoc_pkg::ST_EMIT;
          end else begin
            axis_d  = axis_q + 3'd1;
            state_d = imuoc_pkg::ST_CHECK;
          end
        end
      end
      imuoc_pkg::ST_EMIT: begin
        cmd_o.converged = !first_q && all_q;
        if (sts_i.out_room) begin
          cmd_o.emit = 1'b1;
          first_d = 1'b0;
          state_d = cmd_o.converged ? imuoc_pkg::ST_IDLE : imuoc_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_d = imuoc_pkg::ST_IDLE;
      end
    endcase
  end

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == imuoc_pkg::ST_MEAN_WAIT ||
                        state_q == imuoc_pkg::ST_CORR_WAIT))
    else $error("divider finished outside a wait state");

  a_round_end_starts_means: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imuoc_pkg::ST_ACCUM && accept && !in_kind_i && sts_i.last) |=>
      (state_q == imuoc_pkg::ST_MEAN_GO && axis_q == imuoc_pkg::AXIS_FIRST))
    else $error("round end did not open the mean divisions at the first axis");

  a_converged_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.converged) |=> state_q == imuoc_pkg::ST_IDLE)
    else $error("converged result did not stop calibration");

  a_axis_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q <= imuoc_pkg::AXIS_LAST)
    else $error("axis counter out of range");

  a_first_round_not_converged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && first_q) |-> !cmd_o.converged)
    else $error("first round reported convergence");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for imu_offset_calibrator. A queue-fed driver sends
// start and sample transfers with random gaps while the result side stalls at
// random, except in a final calm phase. A predictor keeps its own copy of the
// calibration state and configuration, works out the offsets each transfer
// should produce, and the monitor checks every result field against the
// oldest prediction. Register reset values are read back over the APB port,
// and settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module tb;

  localparam int COUNT_BITS = 12;
  localparam int SUM_W = COUNT_BITS + 16;
  localparam int FIRST_ACC_DIV = 8;
  localparam int FIRST_GYRO_DIV = 4;
  localparam int DRAIN_CYCLES = 500;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic signed [15:0] S16_MAX = 16'sh7fff;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;
  localparam logic signed [15:0] ONE_G = 16'sd16384;

  typedef enum logic [1:0] {CAL_IDLE, CAL_FIRST, CAL_LATER} cal_phase_e;
  typedef enum int {RND_TIGHT, RND_NEAR, RND_WILD, RND_PINNED} round_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  imuoc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  imuoc_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [imuoc_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [imuoc_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [imuoc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  imu_offset_calibrator #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [COUNT_BITS-1:0] cfg_count = COUNT_BITS'(imuoc_pkg::RST_SAMPLE_COUNT);
  logic [7:0] cfg_warmup = imuoc_pkg::RST_WARMUP_DISCARD;
  logic [7:0] cfg_acc_dz = imuoc_pkg::RST_ACCEL_DEADZONE;
  logic [7:0] cfg_gyro_dz = imuoc_pkg::RST_GYRO_DEADZONE;
  logic [14:0] cfg_one_g = imuoc_pkg::RST_ACCEL_ONE_G;

  cal_phase_e cal_phase = CAL_IDLE;
  int unsigned cal_pos = 0;
  logic signed [SUM_W-1:0] axis_sum [imuoc_pkg::NUM_AXES] = '{default: '0};
  logic signed [15:0] axis_off [imuoc_pkg::NUM_AXES] = '{default: '0};

  imuoc_pkg::in_item_t feed_q[$];
  imuoc_pkg::out_item_t offsets_due[$];
  string field_name [7] = '{"accel_x_offset", "accel_y_offset", "accel_z_offset",
                            "gyro_x_offset", "gyro_y_offset", "gyro_z_offset", "converged"};
  logic in_took = 1'b0;
  bit calm = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int fails = 0;
  int queued = 0;
  longint cycle_count = 0;

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return S16_MAX;
    if (v < -32768) return S16_MIN;
    return v[15:0];
  endfunction

  function automatic bit predict_offsets(input imuoc_pkg::in_item_t it,
                                         output imuoc_pkg::out_item_t res);
    longint smp [imuoc_pkg::NUM_AXES];
    longint err [imuoc_pkg::NUM_AXES];
    longint n, mean, div, dz;
    int settled;
    res = '0;
    if (it.kind) begin
      for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
        axis_sum[k] = '0;
        axis_off[k] = '0;
      end
      cal_pos = 0;
      cal_phase = CAL_FIRST;
      return 1'b1;
    end
    if (cal_phase == CAL_IDLE) return 1'b0;
    smp[0] = longint'(it.accel_x);
    smp[1] = longint'(it.accel_y);
    smp[2] = longint'(it.accel_z);
    smp[3] = longint'(it.gyro_x);
    smp[4] = longint'(it.gyro_y);
    smp[5] = longint'(it.gyro_z);
    n = (cfg_count == 0) ? 64'sd1 : longint'(cfg_count);
    if (cal_pos >= cfg_warmup) begin
      for (int k = 0; k < imuoc_pkg::NUM_AXES; k++)
        axis_sum[k] = SUM_W'(longint'(axis_sum[k]) + smp[k]);
    end
    cal_pos++;
    if (longint'(cal_pos) < longint'(cfg_warmup) + n) return 1'b0;
    for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
      mean = longint'(axis_sum[k]) / n;
      err[k] = (k == imuoc_pkg::AXIS_ACC_Z) ? longint'(cfg_one_g) - mean : -mean;
      axis_sum[k] = '0;
    end
    cal_pos = 0;
    if (cal_phase == CAL_FIRST) begin
      for (int k = 0; k < imuoc_pkg::NUM_AXES; k++)
        axis_off[k] = sat16(err[k] / (k < imuoc_pkg::ACCEL_AXES ? FIRST_ACC_DIV
                                                                : FIRST_GYRO_DIV));
      cal_phase = CAL_LATER;
    end else begin
      settled = 0;
      for (int k = 0; k < imuoc_pkg::NUM_AXES; k++) begin
        if (k < imuoc_pkg::ACCEL_AXES) begin
          dz = longint'(cfg_acc_dz);
          div = (cfg_acc_dz == 0) ? 64'sd1 : longint'(cfg_acc_dz);
        end else begin
          dz = longint'(cfg_gyro_dz);
          div = longint'(cfg_gyro_dz) + 64'sd1;
        end
        if ((err[k] < 0 ? -err[k] : err[k]) <= dz) settled++;
        else axis_off[k] = sat16(longint'(axis_off[k]) + err[k] / div);
      end
      res.converged = (settled == imuoc_pkg::NUM_AXES);
      if (res.converged) cal_phase = CAL_IDLE;
    end
    res.accel_x_offset = axis_off[0];
    res.accel_y_offset = axis_off[1];
    res.accel_z_offset = axis_off[2];
    res.gyro_x_offset = axis_off[3];
    res.gyro_y_offset = axis_off[4];
    res.gyro_z_offset = axis_off[5];
    return 1'b1;
  endfunction

  function automatic logic signed [16:0] field_value(input imuoc_pkg::out_item_t r,
                                                      input int k);
    logic signed [16:0] v;
    case (k)
      0: v = 17'(r.accel_x_offset);
      1: v = 17'(r.accel_y_offset);
      2: v = 17'(r.accel_z_offset);
      3: v = 17'(r.gyro_x_offset);
      4: v = 17'(r.gyro_y_offset);
      5: v = 17'(r.gyro_z_offset);
      default: v = {16'b0, r.converged};
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    imuoc_pkg::out_item_t want;
    logic signed [16:0] want_f, got_f;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    in_took <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (predict_offsets(in_data_i, want)) offsets_due.push_back(want);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (offsets_due.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %p", $time, out_data_o);
        fails++;
      end else begin
        want = offsets_due.pop_front();
        for (int k = 0; k < 7; k++) begin
          want_f = field_value(want, k);
          got_f = field_value(out_data_o, k);
          if (got_f !== want_f) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name[k], want_f, got_f);
            fails++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    logic next_valid;
    next_valid = 1'b0;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else if (in_valid_i && !in_took) begin
      next_valid = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
    end else if (feed_q.size() != 0) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 9);
      end else begin
        in_data_i <= feed_q.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;

    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      imuoc_pkg::REG_SAMPLE_COUNT:   cfg_count = val[COUNT_BITS-1:0];
      imuoc_pkg::REG_WARMUP_DISCARD: cfg_warmup = val[7:0];
      imuoc_pkg::REG_ACCEL_DEADZONE: cfg_acc_dz = val[7:0];
      imuoc_pkg::REG_GYRO_DEADZONE:  cfg_gyro_dz = val[7:0];
      imuoc_pkg::REG_ACCEL_ONE_G:    cfg_one_g = val[14:0];
      default: ;
    endcase
  endtask

  task automatic read_reg(input logic [2:0] idx, input logic [31:0] want);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, want, prdata);
      fails++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_config(input int count, warm, acc_dz, gyro_dz, one_g);
    write_reg(imuoc_pkg::REG_SAMPLE_COUNT, count);
    write_reg(imuoc_pkg::REG_WARMUP_DISCARD, warm);
    write_reg(imuoc_pkg::REG_ACCEL_DEADZONE, acc_dz);
    write_reg(imuoc_pkg::REG_GYRO_DEADZONE, gyro_dz);
    write_reg(imuoc_pkg::REG_ACCEL_ONE_G, one_g);
  endtask

  task automatic random_config();
    int count, warm, acc_dz, gyro_dz, one_g;
    case ($urandom_range(0, 9))
      0: count = 0;
      1: count = 1;
      2: count = $urandom_range(20, 40);
      default: count = $urandom_range(2, 8);
    endcase
    case ($urandom_range(0, 5))
      0: warm = 0;
      1: warm = $urandom_range(10, 20);
      default: warm = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 4))
      0: acc_dz = 0;
      1: acc_dz = 1;
      2: acc_dz = 255;
      default: acc_dz = $urandom_range(1, 255);
    endcase
    case ($urandom_range(0, 3))
      0: gyro_dz = 0;
      1: gyro_dz = 254;
      default: gyro_dz = $urandom_range(0, 254);
    endcase
    case ($urandom_range(0, 4))
      0: one_g = 0;
      1: one_g = 32767;
      2: one_g = int'(imuoc_pkg::RST_ACCEL_ONE_G);
      default: one_g = $urandom_range(0, 32767);
    endcase
    set_config(count, warm, acc_dz, gyro_dz, one_g);
  endtask

  task automatic wait_quiet();
    @(posedge clk_i);
    while (feed_q.size() != 0 || in_valid_i || offsets_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] near_value(input longint centre, input int spread);
    longint v;
    v = centre + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic push_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz);
    imuoc_pkg::in_item_t it;
    it.kind = 1'b0;
    it.accel_x = ax;
    it.accel_y = ay;
    it.accel_z = az;
    it.gyro_x = gx;
    it.gyro_y = gy;
    it.gyro_z = gz;
    feed_q.push_back(it);
    queued++;
  endtask

  task automatic push_noise();
    push_sample(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic push_start();
    logic [127:0] raw;
    imuoc_pkg::in_item_t it;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(imuoc_pkg::in_item_t)-1:0];
    it.kind = 1'b1;
    feed_q.push_back(it);
    queued++;
  endtask

  task automatic push_round(input round_style_e style);
    int n, sa, sg;
    logic signed [15:0] pin [imuoc_pkg::NUM_AXES];
    n = (cfg_count == 0) ? 1 : int'(cfg_count);
    for (int k = 0; k < imuoc_pkg::NUM_AXES; k++)
      pin[k] = $urandom_range(0, 1) ? S16_MAX : S16_MIN;
    sa = (style == RND_TIGHT) ? int'(cfg_acc_dz) : 3 * int'(cfg_acc_dz) + 20;
    sg = (style == RND_TIGHT) ? int'(cfg_gyro_dz) : 3 * int'(cfg_gyro_dz) + 20;
    repeat (cfg_warmup) push_noise();
    repeat (n) begin
      case (style)
        RND_WILD:   push_noise();
        RND_PINNED: push_sample(pin[0], pin[1], pin[2], pin[3], pin[4], pin[5]);
        default:    push_sample(near_value(64'sd0, sa), near_value(64'sd0, sa),
                                near_value(longint'(cfg_one_g), sa),
                                near_value(64'sd0, sg), near_value(64'sd0, sg),
                                near_value(64'sd0, sg));
      endcase
    end
  endtask

  task automatic run_calibration(input int rounds);
    push_start();
    for (int r = 0; r < rounds; r++)
      push_round(r == rounds - 1 ? RND_TIGHT : round_style_e'($urandom_range(0, 3)));
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = queued + budget;
    while (queued < stop) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 4)) push_noise();
        1: begin
          push_start();
          repeat ($urandom_range(0, int'(cfg_warmup) + 1)) push_noise();
        end
        default: run_calibration($urandom_range(1, 5));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values of every register
    read_reg(imuoc_pkg::REG_SAMPLE_COUNT, 32'(imuoc_pkg::RST_SAMPLE_COUNT));
    read_reg(imuoc_pkg::REG_WARMUP_DISCARD, 32'(imuoc_pkg::RST_WARMUP_DISCARD));
    read_reg(imuoc_pkg::REG_ACCEL_DEADZONE, 32'(imuoc_pkg::RST_ACCEL_DEADZONE));
    read_reg(imuoc_pkg::REG_GYRO_DEADZONE, 32'(imuoc_pkg::RST_GYRO_DEADZONE));
    read_reg(imuoc_pkg::REG_ACCEL_ONE_G, 32'(imuoc_pkg::RST_ACCEL_ONE_G));

    // reset settings: samples while idle, then leave a round open in its warm-up
    push_sample(S16_MAX, S16_MIN, S16_MAX, S16_MIN, S16_MAX, S16_MIN);
    push_sample(S16_MIN, S16_MAX, S16_MIN, S16_MAX, S16_MIN, S16_MAX);
    push_start();
    repeat (3) push_noise();
    wait_quiet();

    // shrink the round under an open one, then directed extremes
    set_config(2, 0, 8, 1, int'(ONE_G));
    push_sample(16'sd0, 16'sd0, ONE_G, 16'sd0, 16'sd0, 16'sd0);
    push_start();
    repeat (2) push_sample(S16_MAX, S16_MIN, S16_MAX, S16_MIN, S16_MAX, S16_MIN);
    repeat (2) push_sample(S16_MIN, S16_MAX, S16_MIN, S16_MAX, S16_MIN, S16_MAX);
    repeat (2) push_sample(16'sd0, 16'sd0, ONE_G, 16'sd0, 16'sd0, 16'sd0);
    push_sample(S16_MAX, S16_MAX, S16_MIN, S16_MIN, S16_MAX, S16_MIN);
    push_start();
    push_sample(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    push_start();
    repeat (2) push_sample(16'sd8, -16'sd8, ONE_G + 16'sd8, 16'sd1, -16'sd1, 16'sd0);
    repeat (2) push_sample(-16'sd8, 16'sd8, ONE_G - 16'sd8, -16'sd1, 16'sd1, 16'sd0);
    push_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    wait_quiet();

    // zero count, zero deadzones: drive offsets into saturation
    set_config(0, 3, 0, 0, 0);
    push_start();
    repeat (3) push_round(RND_PINNED);
    repeat (2) push_round(RND_TIGHT);
    wait_quiet();

    // deepest warm-up, widest deadzones, a long round
    set_config(150, 255, 255, 254, 32767);
    push_start();
    push_round(RND_PINNED);
    repeat (3) push_noise();
    wait_quiet();

    repeat (4) begin
      random_config();
      random_phase(80);
      wait_quiet();
    end

    calm = 1'b1;
    random_config();
    random_phase(80);
    wait_quiet();

    if (fails == 0 && offsets_due.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
